[design/dwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_pkg
// shared types and constants of the 3x3 depthwise convolution unit
// ----------------------------------------------------------------------------
package dwc_pkg;

	localparam int MAX_WIDTH_DEF    = 256;
	localparam int MAX_HEIGHT_DEF   = 256;
	localparam int MAX_CHANNELS_DEF = 64;

	localparam int KSIDE = 3;
	localparam int KTAPS = 9;
	localparam int ACC_W = 20;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd3;

	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic signed [7:0]  act_t;
	typedef logic signed [8:0]  diff_t;
	typedef logic signed [16:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef diff_t [KTAPS-1:0] diff_vec_t;
	typedef act_t  [KTAPS-1:0] wt_vec_t;
	typedef prod_t [KTAPS-1:0] prod_vec_t;

	// position and flags that travel with one result
	typedef struct packed {
		logic [5:0] chan;
		logic [7:0] row;
		logic [7:0] col;
		logic       last_run;
		logic       last_tensor;
	} meta_t;

endpackage

[design/dwc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_req_if / dwc_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface dwc_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic signed [7:0] sample;
	logic [5:0]  weight_channel;
	logic [3:0]  weight_tap;
	logic signed [7:0] weight_value;

	modport source (output valid, command, sample, weight_channel, weight_tap,
		weight_value, input ready);
	modport sink (input valid, command, sample, weight_channel, weight_tap,
		weight_value, output ready);
endinterface

interface dwc_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [dwc_pkg::ACC_W-1:0] accumulator;
	logic [5:0]  out_channel;
	logic [7:0]  out_row;
	logic [7:0]  out_column;
	logic        last_in_run;
	logic        last_of_tensor;

	modport source (output valid, accumulator, out_channel, out_row, out_column,
		last_in_run, last_of_tensor, input ready);
	modport sink (input valid, accumulator, out_channel, out_row, out_column,
		last_in_run, last_of_tensor, output ready);
endinterface

[design/dwc_wt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_wt_mem
// per-channel weight table, one row of nine weights per channel
// ----------------------------------------------------------------------------
module dwc_wt_mem #(
	parameter int MAX_CHANNELS = dwc_pkg::MAX_CHANNELS_DEF,
	parameter int CHW = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [CHW-1:0]    waddr,
	input  logic [3:0]        wtap,
	input  dwc_pkg::act_t     wdata,
	input  logic              re,
	input  logic [CHW-1:0]    raddr,
	output dwc_pkg::wt_vec_t  rdata
);
	import dwc_pkg::*;

	wt_vec_t mem [MAX_CHANNELS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wtap] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/dwc_line_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_line_mem
// two line stores packed per column, byte chosen by row parity
// ----------------------------------------------------------------------------
module dwc_line_mem #(
	parameter int MAX_WIDTH = dwc_pkg::MAX_WIDTH_DEF,
	parameter int CW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] addr,
	input  logic          par,
	input  dwc_pkg::act_t wdata,
	output logic [15:0]   rdata
);
	import dwc_pkg::*;

	logic [15:0] mem [MAX_WIDTH];

	// read returns the old entry, write replaces one byte
	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			mem[addr][par*8 +: 8] <= wdata;
		end
	end

endmodule

[design/dwc_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_mac
// nine multipliers, adder and result register
// ----------------------------------------------------------------------------
module dwc_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               iss_v,
	input  dwc_pkg::diff_vec_t diffs,
	input  dwc_pkg::wt_vec_t   wts,
	input  dwc_pkg::meta_t     meta,
	output logic               res_v,
	output dwc_pkg::acc_t      res_acc,
	output dwc_pkg::meta_t     res_meta
);
	import dwc_pkg::*;

	logic      v_s2, v_s3;
	diff_vec_t dif_s2;
	wt_vec_t   wt_s2;
	meta_t     meta_s2, meta_s3;
	prod_vec_t prod_s3;
	acc_t      sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < KTAPS; i++) begin
			sum = sum + {{(ACC_W-17){prod_s3[i][16]}}, prod_s3[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			res_v <= 1'b0;
		end else if (adv) begin
			v_s2  <= iss_v;
			v_s3  <= v_s2;
			res_v <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dif_s2  <= diffs;
			wt_s2   <= wts;
			meta_s2 <= meta;
			for (int i = 0; i < KTAPS; i++) begin
				prod_s3[i] <= $signed(dif_s2[i]) * $signed(wt_s2[i]);
			end
			meta_s3  <= meta_s2;
			res_acc  <= sum;
			res_meta <= meta_s3;
		end
	end

endmodule

[design/depthwise_conv3x3_int8_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_conv3x3_int8_unit
// streaming 3x3 depthwise convolution on int8 samples, stride 1, same padding
// ----------------------------------------------------------------------------
// Samples enter in channel-major raster order, one per cycle while the
// request side is ready; weight loads (command 0) share the request channel
// and write the weight table at once. A sample whose window completes one
// result or none leaves the request side free for the next sample; at the
// last column or last row a sample yields up to four results, issued one per
// advancing cycle from the window stage, so such a sample holds the request
// side until its last result issues. The first result of a request passes
// window select, operand register, multiply, then the sum into the output
// register. A result waiting at the output freezes the whole pipeline and
// the request side with it. Both memories are read on accept and the line
// store is written in the same cycle (old data returned), so no forwarding
// is needed. Memories need no clearing pass: stale line data lies only in
// padded positions. Any configuration write restarts the tensor.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_int8_unit #(
	parameter int MAX_WIDTH    = dwc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = dwc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_CHANNELS = dwc_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dwc_req_if.sink                           req,
	dwc_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [dwc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [dwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import dwc_pkg::*;

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// configuration
	act_t       zp_q;
	logic [8:0] hgt_q, wid_q;
	logic [6:0] chn_q;

	// stream position of the next sample
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [CHW-1:0] chan_q;

	// window stage
	logic           s1_v_q;
	logic [3:0]     pend_q;     // results still to issue: a, b, c, d
	logic [RW-1:0]  s1_row;
	logic [CW-1:0]  s1_col;
	logic [CHW-1:0] s1_chan;
	logic           s1_lch;
	logic           s1_par;
	act_t           s1_sample;
	act_t           win_q [KSIDE][2];   // two older window columns

	logic       adv, s1_free, acc_req, smp_acc, wt_acc, wt_ok;
	logic       lc, lr, lch;
	logic [3:0] pend_new, pick;
	logic       dy, dx, oy0, oyl, ox0, oxl;
	logic [RW-1:0] oy;
	logic [CW-1:0] ox;
	logic [15:0]   ln_rd;
	wt_vec_t       wt_rd;
	act_t          col2 [KSIDE];
	diff_vec_t     diffs;
	meta_t         iss_meta;
	logic          iss_v;
	logic          res_v;
	acc_t          res_acc;
	meta_t         res_meta;

	// the whole pipeline moves unless a result waits at the output
	assign adv     = !res_v || rsp.ready;
	assign s1_free = !s1_v_q || ((pend_q & (pend_q - 4'd1)) == 4'd0);
	assign req.ready = adv && s1_free;
	assign acc_req = req.valid && req.ready;
	assign smp_acc = acc_req && (req.command == CMD_SAMPLE);
	assign wt_ok   = (req.weight_tap < 4'(KTAPS)) &&
		(32'(req.weight_channel) < MAX_CHANNELS);
	assign wt_acc  = acc_req && (req.command == CMD_WEIGHT) && wt_ok;

	// end-of-row / plane / tensor flags at the current position
	assign lc  = (32'(col_q) + 32'd1 == 32'(wid_q));
	assign lr  = (32'(row_q) + 32'd1 == 32'(hgt_q));
	assign lch = (32'(chan_q) + 32'd1 == 32'(chn_q));

	// which windows this sample completes, in emission order
	assign pend_new[0] = (row_q != '0) && (col_q != '0);
	assign pend_new[1] = (row_q != '0) && lc;
	assign pend_new[2] = lr && (col_q != '0);
	assign pend_new[3] = lr && lc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zp_q   <= '0;
			hgt_q  <= 9'd1;
			wid_q  <= 9'd1;
			chn_q  <= 7'd1;
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ZERO_POINT: zp_q <= cfg_wdata[7:0];
				CFG_HEIGHT: begin
					if (cfg_wdata == '0) hgt_q <= 9'd1;
					else if (32'(cfg_wdata) > MAX_HEIGHT) hgt_q <= 9'(MAX_HEIGHT);
					else hgt_q <= cfg_wdata;
				end
				CFG_WIDTH: begin
					if (cfg_wdata == '0) wid_q <= 9'd1;
					else if (32'(cfg_wdata) > MAX_WIDTH) wid_q <= 9'(MAX_WIDTH);
					else wid_q <= cfg_wdata;
				end
				CFG_CHANNELS: begin
					if (cfg_wdata[6:0] == '0) chn_q <= 7'd1;
					else if (32'(cfg_wdata[6:0]) > MAX_CHANNELS) chn_q <= 7'(MAX_CHANNELS);
					else chn_q <= cfg_wdata[6:0];
				end
				default: ;
			endcase
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (smp_acc) begin
			if (lc) begin
				col_q <= '0;
				if (lr) begin
					row_q  <= '0;
					chan_q <= lch ? '0 : chan_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// window stage control: one result issued per advancing cycle
	assign pick = pend_q & (~pend_q + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			pend_q <= '0;
		end else if (adv) begin
			if (smp_acc) begin
				s1_v_q <= 1'b1;
				pend_q <= pend_new;
			end else if (s1_v_q && s1_free) begin
				s1_v_q <= 1'b0;
				pend_q <= '0;
			end else begin
				pend_q <= pend_q & ~pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			s1_row    <= row_q;
			s1_col    <= col_q;
			s1_chan   <= chan_q;
			s1_lch    <= lch;
			s1_par    <= row_q[0];
			s1_sample <= req.sample;
		end
		// the sample leaves the window stage: shift its column in
		if (adv && s1_v_q && s1_free) begin
			for (int k = 0; k < KSIDE; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= col2[k];
			end
		end
	end

	// newest window column: two rows from the line store, then the sample
	assign col2[0] = s1_par ? ln_rd[15:8] : ln_rd[7:0];
	assign col2[1] = s1_par ? ln_rd[7:0] : ln_rd[15:8];
	assign col2[2] = s1_sample;

	// output position of the picked result and its frame edges
	assign dy  = pick[2] | pick[3];
	assign dx  = pick[1] | pick[3];
	assign oy  = dy ? s1_row : s1_row - 1'b1;
	assign ox  = dx ? s1_col : s1_col - 1'b1;
	assign oy0 = (oy == '0);
	assign ox0 = (ox == '0);
	assign oyl = (32'(oy) + 32'd1 == 32'(hgt_q));
	assign oxl = (32'(ox) + 32'd1 == 32'(wid_q));

	// pair window entries with taps; padded taps contribute zero
	always_comb begin
		logic       ok;
		logic [1:0] wy, wx;
		act_t       pix;
		for (int kh = 0; kh < KSIDE; kh++) begin
			for (int kw = 0; kw < KSIDE; kw++) begin
				wy = 2'(kh) + {1'b0, dy};
				wx = 2'(kw) + {1'b0, dx};
				ok = (wy != 2'd3) && (wx != 2'd3) &&
					!(oy0 && kh == 0) && !(oyl && kh == KSIDE - 1) &&
					!(ox0 && kw == 0) && !(oxl && kw == KSIDE - 1);
				if (!ok) pix = '0;
				else if (wx == 2'd2) pix = col2[wy];
				else pix = win_q[wy][wx[0]];
				diffs[kh*KSIDE+kw] = ok ?
					diff_t'($signed({pix[7], pix}) - $signed({zp_q[7], zp_q})) : '0;
			end
		end
	end

	assign iss_v = s1_v_q && (pend_q != '0);
	assign iss_meta.chan        = 6'(s1_chan);
	assign iss_meta.row         = 8'(oy);
	assign iss_meta.col         = 8'(ox);
	assign iss_meta.last_run    = ((pend_q & ~pick) == 4'd0);
	assign iss_meta.last_tensor = pick[3] && s1_lch;

	dwc_wt_mem #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.CHW(CHW)
	) u_wt_mem (
		.clk(clk),
		.we(wt_acc),
		.waddr(CHW'(req.weight_channel)),
		.wtap(req.weight_tap),
		.wdata(req.weight_value),
		.re(smp_acc),
		.raddr(chan_q),
		.rdata(wt_rd)
	);

	dwc_line_mem #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW(CW)
	) u_line_mem (
		.clk(clk),
		.en(smp_acc),
		.addr(col_q),
		.par(row_q[0]),
		.wdata(req.sample),
		.rdata(ln_rd)
	);

	dwc_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.iss_v(iss_v),
		.diffs(diffs),
		.wts(wt_rd),
		.meta(iss_meta),
		.res_v(res_v),
		.res_acc(res_acc),
		.res_meta(res_meta)
	);

	assign rsp.valid          = res_v;
	assign rsp.accumulator    = res_acc;
	assign rsp.out_channel    = res_meta.chan;
	assign rsp.out_row        = res_meta.row;
	assign rsp.out_column     = res_meta.col;
	assign rsp.last_in_run    = res_meta.last_run;
	assign rsp.last_of_tensor = res_meta.last_tensor;

endmodule
